[sv/sed_pkg.sv]
// ----------------------------------------------------------------------------
// sed_pkg
// shared types, constants and helpers of the rgb sobel edge block
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int PIX_W      = 8;
    localparam int CHANS      = 3;
    localparam int GRAD_W     = 11;   // signed gradient, |g| <= 1020
    localparam int SUM_W      = 21;   // gx^2 + gy^2 <= 2080800
    localparam int POS_W      = 10;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 1;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;
    localparam logic [DIM_W-1:0] DIM_MIN   = 11'd3;
    localparam logic [PIX_W-1:0] MAG_MAX   = 8'hFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_t;

    // one line store entry: pixel of row r-2 and of row r-1
    typedef struct packed {
        pix_t older;
        pix_t newer;
    } line_pair_t;

    // 3x3 window without the unused center
    typedef struct packed {
        pix_t tl;
        pix_t tm;
        pix_t tr;
        pix_t ml;
        pix_t mr;
        pix_t bl;
        pix_t bm;
        pix_t br;
    } win_t;

    typedef struct packed {
        logic start;
        win_t win;
    } sed_mag_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } sed_mag_stat_t;

    function automatic logic [PIX_W-1:0] pix_chan(input pix_t p, input logic [1:0] k);
        logic [PIX_W-1:0] v;
        case (k)
            2'd0:    v = p.red;
            2'd1:    v = p.green;
            default: v = p.blue;
        endcase
        return v;
    endfunction

endpackage

[sv/sobel_edge_rgb.sv]
// ----------------------------------------------------------------------------
// sobel_edge_rgb
// streaming 3x3 sobel gradient magnitude over rgb pixels in raster order
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with red_in, green_in, blue_in, one
//   pixel word per accepted handshake, raster order, rows of image_width
//   output channel: out_valid / out_stall with the three clamped magnitudes,
//   center_row, center_col and frame_end; one word per interior pixel only,
//   border rows and columns produce nothing
//   config: cfg_write with cfg_index / cfg_data sets image_width or
//   image_height (clamped to 3..MAX) and restarts the image at (0, 0)
// timing
//   a border pixel occupies the block for the accept and the line store read
//   an interior pixel occupies it through line store read, gradient,
//   square, the bit-serial root and the output load, which sets out_valid
//   the root iteration in sed_mag sets the rate
// stall
//   a finished word sits in the output register; the next pixel is still
//   accepted, only a second result waits until the first one is taken
// reset
//   counters, window and output valid flag clear at once; line stores are not cleared
// ----------------------------------------------------------------------------
module sobel_edge_rgb #(
    parameter int MAX_WIDTH  = sed_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sed_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config port
    input  logic                            cfg_write,
    input  logic [sed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sed_pkg::DIM_W-1:0]       cfg_data,
    // pixel input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sed_pkg::PIX_W-1:0]       red_in,
    input  logic [sed_pkg::PIX_W-1:0]       green_in,
    input  logic [sed_pkg::PIX_W-1:0]       blue_in,
    // edge output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sed_pkg::PIX_W-1:0]       red_edge,
    output logic [sed_pkg::PIX_W-1:0]       green_edge,
    output logic [sed_pkg::PIX_W-1:0]       blue_edge,
    output logic [sed_pkg::POS_W-1:0]       center_row,
    output logic [sed_pkg::POS_W-1:0]       center_col,
    output logic                            frame_end
);
    import sed_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);        // column counter / ram address
    localparam int WW  = $clog2(MAX_WIDTH + 1);    // effective width
    localparam int RAW = $clog2(MAX_HEIGHT);       // row counter
    localparam int HW  = $clog2(MAX_HEIGHT + 1);   // effective height

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC} state_t;

    state_t             state_reg;
    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;
    logic [AW-1:0]      col_count_reg;
    logic [RAW-1:0]     row_count_reg;
    pix_t               win_reg [6];     // tl tm ml mm bl bm
    pix_t               px_reg;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   red_edge_reg;
    logic [PIX_W-1:0]   green_edge_reg;
    logic [PIX_W-1:0]   blue_edge_reg;
    logic [POS_W-1:0]   center_row_reg;
    logic [POS_W-1:0]   center_col_reg;
    logic               frame_end_reg;
    logic [POS_W-1:0]   pend_row_reg;
    logic [POS_W-1:0]   pend_col_reg;
    logic               pend_end_reg;

    logic [WW-1:0]      eff_width;
    logic [HW-1:0]      eff_height;
    logic               in_accept;
    logic               cfg_hit;
    logic               emit;
    logic               last_col;
    logic               last_row;
    logic               out_free;
    logic               load_out;
    line_pair_t         rd_pair;
    line_pair_t         wr_pair;
    sed_mag_ctrl_t      mag_ctrl;
    sed_mag_stat_t      mag_stat;

    // effective dimensions clamped to the supported range
    always_comb
    begin
        if (image_width_reg < DIM_MIN)
        begin
            eff_width = WW'(DIM_MIN);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WW'(image_width_reg);
        end

        if (image_height_reg < DIM_MIN)
        begin
            eff_height = HW'(DIM_MIN);
        end
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
        begin
            eff_height = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_height = HW'(image_height_reg);
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_hit   = cfg_write
                       && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
    assign emit      = (row_count_reg >= RAW'(2)) && (col_count_reg >= AW'(2));
    assign last_col  = (WW'(col_count_reg) + WW'(1)) == eff_width;
    assign last_row  = (HW'(row_count_reg) + HW'(1)) == eff_height;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == S_CALC) && !mag_stat.busy && out_free;

    // line stores: the older line takes the newer one, the newer takes the pixel
    assign wr_pair.older = rd_pair.newer;
    assign wr_pair.newer = px_reg;

    sed_line_mem #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (state_reg == S_READ),
        .wr_addr (col_count_reg),
        .wr_data (wr_pair),
        .rd_en   (in_accept),
        .rd_addr (col_count_reg),
        .rd_data (rd_pair)
    );

    // window around the center pixel, right column from the ram read and the pixel register
    assign mag_ctrl.start  = (state_reg == S_READ) && emit;
    assign mag_ctrl.win.tl = win_reg[0];
    assign mag_ctrl.win.tm = win_reg[1];
    assign mag_ctrl.win.tr = rd_pair.older;
    assign mag_ctrl.win.ml = win_reg[2];
    assign mag_ctrl.win.mr = rd_pair.newer;
    assign mag_ctrl.win.bl = win_reg[4];
    assign mag_ctrl.win.bm = win_reg[5];
    assign mag_ctrl.win.br = px_reg;

    sed_mag u_mag (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mag_ctrl),
        .stat  (mag_stat)
    );

    // sequencer and output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= emit ? S_CALC : S_IDLE;
                end
                S_CALC:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // config registers, position counters and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_RESET;
            image_height_reg <= DIM_RESET;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          image_width_reg  <= image_width_reg;
            endcase
            // any write restarts the image
            col_count_reg <= '0;
            row_count_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (state_reg == S_READ)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= rd_pair.older;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= rd_pair.newer;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= px_reg;
            if (last_col)
            begin
                col_count_reg <= '0;
                row_count_reg <= last_row ? '0 : row_count_reg + RAW'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + AW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            px_reg.red   <= red_in;
            px_reg.green <= green_in;
            px_reg.blue  <= blue_in;
        end
        if (state_reg == S_READ)
        begin
            pend_row_reg <= POS_W'(row_count_reg - RAW'(1));
            pend_col_reg <= POS_W'(col_count_reg - AW'(1));
            pend_end_reg <= last_row && last_col;
        end
        if (load_out)
        begin
            red_edge_reg   <= mag_stat.red;
            green_edge_reg <= mag_stat.green;
            blue_edge_reg  <= mag_stat.blue;
            center_row_reg <= pend_row_reg;
            center_col_reg <= pend_col_reg;
            frame_end_reg  <= pend_end_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_edge   = red_edge_reg;
    assign green_edge = green_edge_reg;
    assign blue_edge  = blue_edge_reg;
    assign center_row = center_row_reg;
    assign center_col = center_col_reg;
    assign frame_end  = frame_end_reg;

    // an interior pixel always starts the magnitude unit
    a_mag_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && emit) |=> mag_stat.busy)
        else $error("magnitude unit not started for interior pixel");

    // position counters stay inside the image
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(col_count_reg) < eff_width) && (HW'(row_count_reg) < eff_height))
        else $error("position counter outside image");

    // a new output word only comes from a finished calculation
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_CALC && !mag_stat.busy))
        else $error("output word without finished magnitude");

    // the line store is never written and read in the same cycle
    a_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && state_reg == S_READ))
        else $error("line store read during write-back");

endmodule

[sv/sed_line_mem.sv]
// ----------------------------------------------------------------------------
// sed_line_mem
// two line stores packed in one synchronous ram, one write and one read port
// ----------------------------------------------------------------------------
module sed_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  sed_pkg::line_pair_t wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output sed_pkg::line_pair_t rd_data
);
    import sed_pkg::*;

    line_pair_t mem [DEPTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/sed_mag.sv]
// ----------------------------------------------------------------------------
// sed_mag
// per-channel sobel gradients, squared sum and bit-serial integer root
// ----------------------------------------------------------------------------
module sed_mag (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sed_pkg::sed_mag_ctrl_t ctrl,
    output sed_pkg::sed_mag_stat_t stat
);
    import sed_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_SQ, M_ROOT} mstate_t;

    mstate_t                   state_reg;
    logic [2:0]                bit_reg;
    logic signed [GRAD_W-1:0]  gx_reg   [CHANS];
    logic signed [GRAD_W-1:0]  gy_reg   [CHANS];
    logic [SUM_W-1:0]          sum_reg  [CHANS];
    logic [PIX_W-1:0]          root_reg [CHANS];

    logic signed [GRAD_W-1:0]  gx_next  [CHANS];
    logic signed [GRAD_W-1:0]  gy_next  [CHANS];
    logic [SUM_W-1:0]          sum_next [CHANS];
    logic [PIX_W-1:0]          root_next[CHANS];

    // gradients straight from the window
    always_comb
    begin
        for (int k = 0; k < CHANS; k++)
        begin
            gx_next[k] =
                (GRAD_W'(pix_chan(ctrl.win.tl, 2'(k)))
                 + (GRAD_W'(pix_chan(ctrl.win.ml, 2'(k))) << 1)
                 + GRAD_W'(pix_chan(ctrl.win.bl, 2'(k))))
              - (GRAD_W'(pix_chan(ctrl.win.tr, 2'(k)))
                 + (GRAD_W'(pix_chan(ctrl.win.mr, 2'(k))) << 1)
                 + GRAD_W'(pix_chan(ctrl.win.br, 2'(k))));
            gy_next[k] =
                (GRAD_W'(pix_chan(ctrl.win.tl, 2'(k)))
                 + (GRAD_W'(pix_chan(ctrl.win.tm, 2'(k))) << 1)
                 + GRAD_W'(pix_chan(ctrl.win.tr, 2'(k))))
              - (GRAD_W'(pix_chan(ctrl.win.bl, 2'(k)))
                 + (GRAD_W'(pix_chan(ctrl.win.bm, 2'(k))) << 1)
                 + GRAD_W'(pix_chan(ctrl.win.br, 2'(k))));
        end
    end

    // squares, then one root bit per cycle
    always_comb
    begin
        logic signed [2*GRAD_W-1:0] sq_x;
        logic signed [2*GRAD_W-1:0] sq_y;
        logic [PIX_W-1:0]           trial;
        logic [2*PIX_W-1:0]         trial_sq;
        for (int k = 0; k < CHANS; k++)
        begin
            sq_x         = (2*GRAD_W)'(gx_reg[k]) * (2*GRAD_W)'(gx_reg[k]);
            sq_y         = (2*GRAD_W)'(gy_reg[k]) * (2*GRAD_W)'(gy_reg[k]);
            sum_next[k]  = SUM_W'(sq_x) + SUM_W'(sq_y);
            trial        = root_reg[k] | (PIX_W'(1) << bit_reg);
            trial_sq     = (2*PIX_W)'(trial) * (2*PIX_W)'(trial);
            if (sum_reg[k][SUM_W-1:2*PIX_W] != '0)
            begin
                root_next[k] = MAG_MAX;     // sum of at least 65536 clamps
            end
            else if (trial_sq <= sum_reg[k][2*PIX_W-1:0])
            begin
                root_next[k] = trial;
            end
            else
            begin
                root_next[k] = root_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                M_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        state_reg <= M_SQ;
                    end
                end
                M_SQ:
                begin
                    bit_reg   <= 3'(PIX_W - 1);
                    state_reg <= M_ROOT;
                end
                M_ROOT:
                begin
                    bit_reg <= bit_reg - 3'd1;
                    if (bit_reg == '0)
                    begin
                        state_reg <= M_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CHANS; k++)
        begin
            if (state_reg == M_IDLE && ctrl.start)
            begin
                gx_reg[k] <= gx_next[k];
                gy_reg[k] <= gy_next[k];
            end
            if (state_reg == M_SQ)
            begin
                sum_reg[k]  <= sum_next[k];
                root_reg[k] <= '0;
            end
            if (state_reg == M_ROOT)
            begin
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign stat.busy  = (state_reg != M_IDLE);
    assign stat.red   = root_reg[0];
    assign stat.green = root_reg[1];
    assign stat.blue  = root_reg[2];

endmodule
